// ===== rtl/hpvf_pkg.sv =====
// ----------------------------------------------------------------------------
// hpvf_pkg
// Shared constants, payload types and control types of the histogram peak
// and valley finder.
// ----------------------------------------------------------------------------
package hpvf_pkg;

   localparam int NUM_BINS   = 32768;
   localparam int MAX_PEAKS  = 128;
   localparam int MAX_VOXELS = 16777216;

   localparam int BIN_W      = $clog2(NUM_BINS);
   localparam int NBIN_W     = BIN_W + 1;
   localparam int TAG_W      = BIN_W + 2;
   localparam int CNT_W      = $clog2(MAX_VOXELS) + 1;
   localparam int PEAK_CNT_W = $clog2(MAX_PEAKS + 1);
   localparam int PROD_W     = 32;
   localparam int PCT_W      = 7;

   localparam logic signed [TAG_W-1:0] TAG_NUM_BINS = TAG_W'(NUM_BINS);

   // base bin must stay this many bins below the occupied end
   localparam logic [NBIN_W:0] MIN_SPAN = 9;

   localparam logic [PROD_W-1:0] PCT_SCALE = 100;
   localparam logic [PROD_W-1:0] PCT_ROUND = 99;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_ALL_ZERO  = 2'd1;
   localparam logic [1:0] STATUS_BASE_HIGH = 2'd2;
   localparam logic [1:0] STATUS_NO_MAXIMA = 2'd3;

   localparam logic [1:0] CSR_BASE_PERCENT = 2'd0;
   localparam logic [1:0] CSR_TOP_PERCENT  = 2'd1;
   localparam logic [1:0] CSR_MIN_BASE_BIN = 2'd2;

   localparam logic [PCT_W-1:0] BASE_PERCENT_RESET = 7'd50;
   localparam logic [PCT_W-1:0] TOP_PERCENT_RESET  = 7'd98;
   localparam logic [14:0]      MIN_BASE_RESET     = 15'd1;

   typedef struct packed {
      logic signed [15:0] voxel_value;
      logic               last_voxel;
   } hpvf_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [14:0] base_bin;
      logic [14:0] top_bin;
      logic [14:0] gray_peak;
      logic [15:0] white_peak;
      logic [24:0] in_range_count;
   } hpvf_rsp_type;

   typedef struct packed {
      logic                    start;
      logic                    kill;
      logic                    down;
      logic signed [TAG_W-1:0] first;
      logic signed [TAG_W-1:0] last;
   } hpvf_scan_cmd_type;

   typedef struct packed {
      logic                    valid;
      logic signed [TAG_W-1:0] tag;
      logic [CNT_W-1:0]        data;
   } hpvf_beat_type;

   typedef struct packed {
      logic                    valid;
      logic                    busy;
      logic signed [TAG_W-1:0] center;
      logic [CNT_W-1:0]        value;
      logic                    is_peak;
      logic                    is_valley;
   } hpvf_win_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_INGEST,
      ST_DRAIN,
      ST_PCT,
      ST_CHECK,
      ST_PEAKS,
      ST_VALLEY,
      ST_FINAL,
      ST_SUM,
      ST_EMIT
   } hpvf_state_type;

endpackage

// ===== rtl/hpvf_ram.sv =====
// ----------------------------------------------------------------------------
// hpvf_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hpvf_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/hpvf_scan.sv =====
// ----------------------------------------------------------------------------
// hpvf_scan
// Address sweep over the histogram memory, up or down, one bin a cycle.
// Bins outside the memory come back as zero.
// ----------------------------------------------------------------------------
module hpvf_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  hpvf_pkg::hpvf_scan_cmd_type   cmd,
   output logic                          rd_en,
   output logic [hpvf_pkg::BIN_W-1:0]    rd_addr,
   input  logic [hpvf_pkg::CNT_W-1:0]    rd_data,
   output hpvf_pkg::hpvf_beat_type       beat,
   output logic                          busy
);
   import hpvf_pkg::*;

   logic                    act_ff, act_in;
   logic signed [TAG_W-1:0] pos_ff, pos_in;
   logic signed [TAG_W-1:0] last_ff, last_in;
   logic                    down_ff, down_in;
   logic                    bt_v_ff, bt_v_in;
   logic signed [TAG_W-1:0] bt_tag_ff, bt_tag_in;
   logic                    bt_zero_ff, bt_zero_in;
   logic                    in_range;

   always_comb begin
      in_range   = (pos_ff >= 0) && (pos_ff < TAG_NUM_BINS);
      rd_en      = act_ff && in_range;
      rd_addr    = pos_ff[BIN_W-1:0];
      bt_v_in    = act_ff;
      bt_tag_in  = pos_ff;
      bt_zero_in = !in_range;
      act_in     = act_ff;
      pos_in     = pos_ff;
      last_in    = last_ff;
      down_in    = down_ff;
      if (act_ff) begin
         pos_in = down_ff ? TAG_W'(pos_ff - 1) : TAG_W'(pos_ff + 1);
         if (pos_ff == last_ff) begin
            act_in = 1'b0;
         end
      end
      if (cmd.start) begin
         act_in  = 1'b1;
         pos_in  = cmd.first;
         last_in = cmd.last;
         down_in = cmd.down;
      end
      if (cmd.kill) begin
         act_in  = 1'b0;
         bt_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      last_ff    <= last_in;
      down_ff    <= down_in;
      bt_tag_ff  <= bt_tag_in;
      bt_zero_ff <= bt_zero_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff  <= 1'b0;
         bt_v_ff <= 1'b0;
      end else begin
         act_ff  <= act_in;
         bt_v_ff <= bt_v_in;
      end
   end

   always_comb begin
      beat.valid = bt_v_ff;
      beat.tag   = bt_tag_ff;
      beat.data  = bt_zero_ff ? '0 : rd_data;
      busy       = act_ff || bt_v_ff;
   end

endmodule

// ===== rtl/hpvf_window.sv =====
// ----------------------------------------------------------------------------
// hpvf_window
// Sliding window over swept bins: 1-2-1 smoothing inside the smoothing band,
// then a three-bin window of smoothed values for peak and valley tests.
// ----------------------------------------------------------------------------
module hpvf_window (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          kill,
   input  logic                          down,
   input  hpvf_pkg::hpvf_beat_type       beat,
   input  logic [hpvf_pkg::NBIN_W-1:0]   sm_lo,
   input  logic [hpvf_pkg::NBIN_W-1:0]   sm_hi,
   output hpvf_pkg::hpvf_win_type        win
);
   import hpvf_pkg::*;

   logic [CNT_W-1:0]        rw_ff [3];
   logic [CNT_W-1:0]        rw_in [3];
   logic signed [TAG_W-1:0] rw_tag_ff, rw_tag_in;
   logic                    rw_v_ff, rw_v_in;
   logic [CNT_W-1:0]        sw_ff [3];
   logic [CNT_W-1:0]        sw_in [3];
   logic signed [TAG_W-1:0] sw_tag_ff, sw_tag_in;
   logic                    sw_v_ff, sw_v_in;
   logic signed [TAG_W-1:0] ctr;
   logic                    in_band;
   logic [CNT_W+1:0]        smooth_sum;
   logic [CNT_W-1:0]        sm_val;

   always_comb begin
      rw_in     = rw_ff;
      rw_tag_in = rw_tag_ff;
      rw_v_in   = beat.valid;
      if (beat.valid) begin
         rw_in[0]  = rw_ff[1];
         rw_in[1]  = rw_ff[2];
         rw_in[2]  = beat.data;
         rw_tag_in = beat.tag;
      end

      // center bin of the raw window lags the newest bin by one
      ctr        = down ? TAG_W'(rw_tag_ff + 1) : TAG_W'(rw_tag_ff - 1);
      in_band    = (ctr >= $signed({1'b0, sm_lo})) && (ctr < $signed({1'b0, sm_hi}));
      smooth_sum = {2'b00, rw_ff[0]} + {1'b0, rw_ff[1], 1'b0} + {2'b00, rw_ff[2]};
      sm_val     = in_band ? smooth_sum[CNT_W+1:2] : rw_ff[1];

      sw_in     = sw_ff;
      sw_tag_in = sw_tag_ff;
      sw_v_in   = rw_v_ff;
      if (rw_v_ff) begin
         sw_in[0]  = sw_ff[1];
         sw_in[1]  = sw_ff[2];
         sw_in[2]  = sm_val;
         sw_tag_in = ctr;
      end

      if (kill) begin
         rw_v_in = 1'b0;
         sw_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rw_ff     <= rw_in;
      rw_tag_ff <= rw_tag_in;
      sw_ff     <= sw_in;
      sw_tag_ff <= sw_tag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rw_v_ff <= 1'b0;
         sw_v_ff <= 1'b0;
      end else begin
         rw_v_ff <= rw_v_in;
         sw_v_ff <= sw_v_in;
      end
   end

   always_comb begin
      win.valid     = sw_v_ff;
      win.busy      = rw_v_ff || sw_v_ff;
      win.center    = down ? TAG_W'(sw_tag_ff + 1) : TAG_W'(sw_tag_ff - 1);
      win.value     = sw_ff[1];
      win.is_peak   = (sw_ff[1] > sw_ff[0]) && (sw_ff[1] > sw_ff[2]);
      win.is_valley = (sw_ff[1] < sw_ff[0]) && (sw_ff[1] < sw_ff[2]);
   end

endmodule

// ===== rtl/histogram_peak_valley_finder.sv =====
// ----------------------------------------------------------------------------
// histogram_peak_valley_finder
// Voxel histogram with percentile limits, smoothed peak search and valley
// search; one result item per data set.
// ----------------------------------------------------------------------------
// Throughput: one voxel item per cycle while a data set streams in (memory
//   read-modify-write with forwarding of the previous increment).
// After the last voxel, up to four phases follow (percentile, peaks, valley,
//   sum), nbin being the highest occupied bin + 1; each phase is a sweep of
//   the single histogram memory read port.
// Then a clearing pass over bins 0 to nbin - 1 runs before the next voxel is taken.
// Reset: synchronous; a clearing pass over all bins follows, req_stall high.
module histogram_peak_valley_finder (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  hpvf_pkg::hpvf_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output hpvf_pkg::hpvf_rsp_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [14:0]            csr_data
);
   import hpvf_pkg::*;

   hpvf_state_type        state_ff, state_in;
   logic [BIN_W-1:0]      clr_ff, clr_in;
   logic [BIN_W-1:0]      maxbin_ff, maxbin_in;
   logic [CNT_W-1:0]      total_ff, total_in;
   logic [PCT_W-1:0]      base_pct_ff;
   logic [PCT_W-1:0]      top_pct_ff;
   logic [14:0]           min_base_ff;

   logic                  iv_ff, iv_in;
   logic [BIN_W-1:0]      ia_ff, ia_in;
   logic                  fw_v_ff, fw_v_in;
   logic [BIN_W-1:0]      fw_a_ff, fw_a_in;
   logic [CNT_W-1:0]      fw_d_ff, fw_d_in;

   logic [PROD_W-1:0]     pb_ff, pb_in, pt_ff, pt_in;
   logic [CNT_W-1:0]      acc_ff, acc_in;
   logic                  pc_v_ff, pc_v_in;
   logic signed [TAG_W-1:0] pc_tag_ff, pc_tag_in;
   logic                  fb_ff, fb_in, ft_ff, ft_in;
   logic [NBIN_W-1:0]     kb_ff, kb_in, kt_ff, kt_in;
   logic [NBIN_W-1:0]     nbot_ff, nbot_in;
   logic [NBIN_W-1:0]     hmax_ff, hmax_in;

   logic [PEAK_CNT_W-1:0] pk_cnt_ff, pk_cnt_in;
   logic [BIN_W-1:0]      i1_ff, i1_in, i2_ff, i2_in;
   logic [CNT_W-1:0]      f1_ff, f1_in, f2_ff, f2_in;
   logic [BIN_W-1:0]      npeak_ff, npeak_in, ntop_ff, ntop_in;
   logic [BIN_W-1:0]      vk_ff, vk_in;
   logic [BIN_W-1:0]      hmin_ff, hmin_in;
   logic [CNT_W-1:0]      sum_ff, sum_in;
   logic [1:0]            status_ff, status_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   hpvf_rsp_type          rsp_ff, rsp_in;

   logic                  req_take, counted, rsp_load;
   logic [BIN_W-1:0]      voxel_bin;
   logic [NBIN_W-1:0]     nbin;
   logic [CNT_W-1:0]      cur_count;
   logic [PROD_W-1:0]     scaled;
   logic [NBIN_W-1:0]     pct_bin;
   logic [BIN_W-1:0]      c_bin;
   logic [15:0]           mirror;

   logic                  ram_we, ram_re;
   logic [BIN_W-1:0]      ram_wa, ram_ra;
   logic [CNT_W-1:0]      ram_wd, ram_rd;

   hpvf_scan_cmd_type     scan_cmd;
   logic                  scan_re;
   logic [BIN_W-1:0]      scan_ra;
   hpvf_beat_type         beat;
   logic                  scan_busy;
   hpvf_win_type          win;
   logic                  win_down;

   hpvf_ram #(
      .DEPTH (NUM_BINS),
      .WIDTH (CNT_W)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   hpvf_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .cmd     (scan_cmd),
      .rd_en   (scan_re),
      .rd_addr (scan_ra),
      .rd_data (ram_rd),
      .beat    (beat),
      .busy    (scan_busy)
   );

   hpvf_window u_window (
      .clock (clock),
      .reset (reset),
      .kill  (scan_cmd.kill),
      .down  (win_down),
      .beat  (beat),
      .sm_lo (nbot_ff),
      .sm_hi (nbin),
      .win   (win)
   );

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_pct_ff <= BASE_PERCENT_RESET;
         top_pct_ff  <= TOP_PERCENT_RESET;
         min_base_ff <= MIN_BASE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BASE_PERCENT: base_pct_ff <= csr_data[PCT_W-1:0];
            CSR_TOP_PERCENT:  top_pct_ff  <= csr_data[PCT_W-1:0];
            CSR_MIN_BASE_BIN: min_base_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      nbin      = NBIN_W'({1'b0, maxbin_ff} + 1'b1);
      req_stall = (state_ff != ST_INGEST);
      req_take  = req_valid && !req_stall;
      counted   = !req_data.voxel_value[15] && (total_ff < CNT_W'(MAX_VOXELS));
      voxel_bin = (req_data.voxel_value > 16'(NUM_BINS - 1)) ? BIN_W'(NUM_BINS - 1)
                                                             : req_data.voxel_value[BIN_W-1:0];
      cur_count = (fw_v_ff && (fw_a_ff == ia_ff)) ? fw_d_ff : ram_rd;
      scaled    = PROD_W'(acc_ff) * PCT_SCALE + PCT_ROUND;
      c_bin     = win.center[BIN_W-1:0];
      mirror    = 16'({1'b0, npeak_ff} + {1'b0, npeak_ff} - {1'b0, vk_ff});
      rsp_load  = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
      win_down  = (state_ff == ST_VALLEY);

      state_in  = state_ff;
      clr_in    = clr_ff;
      maxbin_in = maxbin_ff;
      total_in  = total_ff;
      iv_in     = 1'b0;
      ia_in     = ia_ff;
      fw_v_in   = fw_v_ff;
      fw_a_in   = fw_a_ff;
      fw_d_in   = fw_d_ff;
      pb_in     = pb_ff;
      pt_in     = pt_ff;
      acc_in    = acc_ff;
      pc_v_in   = 1'b0;
      pc_tag_in = beat.tag;
      fb_in     = fb_ff;
      ft_in     = ft_ff;
      kb_in     = kb_ff;
      kt_in     = kt_ff;
      nbot_in   = nbot_ff;
      hmax_in   = hmax_ff;
      pk_cnt_in = pk_cnt_ff;
      i1_in     = i1_ff;
      i2_in     = i2_ff;
      f1_in     = f1_ff;
      f2_in     = f2_ff;
      npeak_in  = npeak_ff;
      ntop_in   = ntop_ff;
      vk_in     = vk_ff;
      hmin_in   = hmin_ff;
      sum_in    = sum_ff;
      status_in = status_ff;
      pct_bin   = '0;

      scan_cmd       = '0;
      ram_re         = scan_re;
      ram_ra         = scan_ra;
      ram_we         = 1'b0;
      ram_wa         = ia_ff;
      ram_wd         = CNT_W'(cur_count + 1'b1);

      // second half of the increment: write back, remember for forwarding
      if (iv_ff) begin
         ram_we  = 1'b1;
         fw_v_in = 1'b1;
         fw_a_in = ia_ff;
         fw_d_in = ram_wd;
      end

      // percentile compare on the registered running sum and the tag of its last bin
      if (pc_v_ff) begin
         if (!fb_ff && (scaled >= pb_ff)) begin
            fb_in = 1'b1;
            kb_in = pc_tag_ff[NBIN_W-1:0];
         end
         if (!ft_ff && (scaled >= pt_ff)) begin
            ft_in = 1'b1;
            kt_in = pc_tag_ff[NBIN_W-1:0];
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we  = 1'b1;
            ram_wa  = clr_ff;
            ram_wd  = '0;
            fw_v_in = 1'b0;
            clr_in  = BIN_W'(clr_ff + 1'b1);
            if (clr_ff == maxbin_ff) begin
               maxbin_in = '0;
               total_in  = '0;
               pk_cnt_in = '0;
               state_in  = ST_INGEST;
            end
         end
         ST_INGEST: begin
            ram_re = req_take && counted;
            ram_ra = voxel_bin;
            if (req_take) begin
               if (counted) begin
                  iv_in    = 1'b1;
                  ia_in    = voxel_bin;
                  total_in = CNT_W'(total_ff + 1'b1);
                  if (voxel_bin > maxbin_ff) begin
                     maxbin_in = voxel_bin;
                  end
               end
               if (req_data.last_voxel) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            // last increment lands this cycle; sweeps start after it
            pb_in  = PROD_W'(base_pct_ff) * PROD_W'(total_ff);
            pt_in  = PROD_W'(top_pct_ff) * PROD_W'(total_ff);
            acc_in = '0;
            fb_in  = 1'b0;
            ft_in  = 1'b0;
            if (maxbin_ff == '0) begin
               status_in = STATUS_ALL_ZERO;
               state_in  = ST_EMIT;
            end else begin
               scan_cmd.start = 1'b1;
               scan_cmd.first = '0;
               scan_cmd.last  = TAG_W'({2'b00, maxbin_ff});
               state_in       = ST_PCT;
            end
         end
         ST_PCT: begin
            if (beat.valid) begin
               acc_in  = CNT_W'(acc_ff + beat.data);
               pc_v_in = 1'b1;
            end
            if (!scan_busy && !pc_v_ff) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            pct_bin = fb_ff ? kb_ff : nbin;
            if (pct_bin == '0) begin
               pct_bin = NBIN_W'(1);
            end
            if ({1'b0, min_base_ff} > pct_bin) begin
               pct_bin = {1'b0, min_base_ff};
            end
            nbot_in   = pct_bin;
            hmax_in   = ft_ff ? kt_ff : nbin;
            pk_cnt_in = '0;
            if (({1'b0, pct_bin} + MIN_SPAN) >= {1'b0, nbin}) begin
               status_in = STATUS_BASE_HIGH;
               state_in  = ST_EMIT;
            end else begin
               scan_cmd.start = 1'b1;
               scan_cmd.first = TAG_W'({1'b0, pct_bin} - 1'b1);
               scan_cmd.last  = TAG_W'({1'b0, nbin} + 1'b1);
               state_in       = ST_PEAKS;
            end
         end
         ST_PEAKS: begin
            if (win.valid && win.is_peak &&
                (win.center > $signed({1'b0, nbot_ff})) &&
                (win.center < $signed({1'b0, nbin})) &&
                (pk_cnt_ff < PEAK_CNT_W'(MAX_PEAKS))) begin
               pk_cnt_in = PEAK_CNT_W'(pk_cnt_ff + 1'b1);
               if (pk_cnt_ff == '0) begin
                  i1_in = c_bin;
                  f1_in = win.value;
               end else if (win.value > f1_ff) begin
                  i2_in = i1_ff;
                  f2_in = f1_ff;
                  i1_in = c_bin;
                  f1_in = win.value;
               end else if ((pk_cnt_ff == PEAK_CNT_W'(1)) || (win.value > f2_ff)) begin
                  i2_in = c_bin;
                  f2_in = win.value;
               end
            end
            if (!scan_busy && !win.busy) begin
               if (pk_cnt_ff == '0) begin
                  status_in = STATUS_NO_MAXIMA;
                  state_in  = ST_EMIT;
               end else begin
                  if (pk_cnt_ff == PEAK_CNT_W'(1)) begin
                     npeak_in = i1_ff;
                  end else begin
                     npeak_in = (i1_ff < i2_ff) ? i1_ff : i2_ff;
                  end
                  ntop_in        = (i1_ff < i2_ff) ? i2_ff : i1_ff;
                  vk_in          = '0;
                  scan_cmd.start = 1'b1;
                  scan_cmd.down  = 1'b1;
                  scan_cmd.first = TAG_W'({2'b00, npeak_in} + 1'b1);
                  scan_cmd.last  = '1;
                  state_in       = ST_VALLEY;
               end
            end
         end
         ST_VALLEY: begin
            if (win.valid && win.is_valley && (win.center > 0) &&
                (win.center < $signed({2'b00, npeak_ff}))) begin
               // first valley below the gray peak: stop the sweep
               vk_in         = c_bin;
               scan_cmd.kill = 1'b1;
               state_in      = ST_FINAL;
            end else if (!scan_busy && !win.busy) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            hmin_in   = (vk_ff > nbot_ff[BIN_W-1:0]) ? vk_ff : nbot_ff[BIN_W-1:0];
            sum_in    = '0;
            status_in = STATUS_OK;
            if ({1'b0, hmin_in} < hmax_ff) begin
               scan_cmd.start = 1'b1;
               scan_cmd.first = TAG_W'({2'b00, hmin_in});
               scan_cmd.last  = TAG_W'({1'b0, hmax_ff} - 1'b1);
               state_in       = ST_SUM;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SUM: begin
            if (beat.valid) begin
               sum_in = CNT_W'(sum_ff + beat.data);
            end
            if (!scan_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               clr_in   = '0;
               state_in = ST_CLEAR;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         rsp_in.status = status_ff;
         if (status_ff == STATUS_OK) begin
            rsp_in.base_bin   = 15'(hmin_ff);
            rsp_in.top_bin    = (hmax_ff > NBIN_W'(NUM_BINS - 1)) ? 15'(NUM_BINS - 1)
                                                                  : 15'(hmax_ff);
            rsp_in.gray_peak  = 15'(npeak_ff);
            rsp_in.white_peak = (pk_cnt_ff == PEAK_CNT_W'(1)) ? mirror : 16'(ntop_ff);
            rsp_in.in_range_count = 25'(sum_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      ia_ff     <= ia_in;
      fw_a_ff   <= fw_a_in;
      fw_d_ff   <= fw_d_in;
      pb_ff     <= pb_in;
      pt_ff     <= pt_in;
      acc_ff    <= acc_in;
      pc_tag_ff <= pc_tag_in;
      fb_ff     <= fb_in;
      ft_ff     <= ft_in;
      kb_ff     <= kb_in;
      kt_ff     <= kt_in;
      nbot_ff   <= nbot_in;
      hmax_ff   <= hmax_in;
      i1_ff     <= i1_in;
      i2_ff     <= i2_in;
      f1_ff     <= f1_in;
      f2_ff     <= f2_in;
      npeak_ff  <= npeak_in;
      ntop_ff   <= ntop_in;
      vk_ff     <= vk_in;
      hmin_ff   <= hmin_in;
      sum_ff    <= sum_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         maxbin_ff    <= BIN_W'(NUM_BINS - 1);
         total_ff     <= '0;
         iv_ff        <= 1'b0;
         fw_v_ff      <= 1'b0;
         pc_v_ff      <= 1'b0;
         pk_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         maxbin_ff    <= maxbin_in;
         total_ff     <= total_in;
         iv_ff        <= iv_in;
         fw_v_ff      <= fw_v_in;
         pc_v_ff      <= pc_v_in;
         pk_cnt_ff    <= pk_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_ingest_during_sweep: assert property (@(posedge clock) disable iff (reset)
      iv_ff |-> !scan_busy)
      else $error("histogram increment overlaps a memory sweep");

   a_stall_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.last_voxel) |=> req_stall)
      else $error("item taken after the last voxel of a data set");

   a_peak_count_bound: assert property (@(posedge clock) disable iff (reset)
      pk_cnt_ff <= PEAK_CNT_W'(MAX_PEAKS))
      else $error("maxima count beyond its limit");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != STATUS_OK)) |->
         ((rsp_data.base_bin == '0) && (rsp_data.top_bin == '0) &&
          (rsp_data.gray_peak == '0) && (rsp_data.white_peak == '0) &&
          (rsp_data.in_range_count == '0)))
      else $error("non-ok result carries nonzero fields");

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the histogram peak and valley finder. Voxel data
// sets stream in under random sender gaps and receiver stalls; a software
// histogram predicts each set's result, which is compared field by field.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hpvf_pkg::*;

   localparam int LIMIT_CYCLES = 12000000;
   localparam int DRAIN_CYCLES = 34000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   hpvf_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   hpvf_rsp_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = CSR_BASE_PERCENT;
   logic [14:0]  csr_data = '0;

   histogram_peak_valley_finder dut (.*);

   always #1 clock = ~clock;

   // predictor state
   int unsigned  raw_bins[NUM_BINS];
   int unsigned  smooth_bins[NUM_BINS];
   int unsigned  peak_bins[MAX_PEAKS];
   int unsigned  voxel_count;
   int           top_touched;
   int unsigned  cfg_base_pct = 50;
   int unsigned  cfg_top_pct = 98;
   int unsigned  cfg_min_base = 1;

   hpvf_rsp_type expected_rsp_q[$];
   int           cycle_count;
   int           mismatch_count;
   int           sender_idle_pct;
   int           receiver_stall_pct;
   int           large_sets;

   function automatic int unsigned raw_at(int k);
      return (k >= 0 && k < NUM_BINS) ? raw_bins[k] : 0;
   endfunction

   function automatic int unsigned smooth_at(int k);
      return (k >= 0 && k < NUM_BINS) ? smooth_bins[k] : 0;
   endfunction

   function automatic int percentile_bin(int unsigned pct, int nbin);
      longint unsigned target;
      longint unsigned acc;
      int k;
      target = (longint'(pct) * voxel_count) / 100;
      acc = 0;
      for (k = 0; k < nbin; k++) begin
         acc += raw_bins[k];
         if (acc >= target) break;
      end
      return k;
   endfunction

   function automatic hpvf_rsp_type histogram_limits();
      hpvf_rsp_type r;
      int k, nbin, nbot, hmin, hmax, npeak, ntop, gpeak, wpeak, n_max;
      int i1, i2, j;
      int unsigned f1, f2, fk;
      longint unsigned numpts;
      bit one_peak;
      r = '0;
      for (k = NUM_BINS - 1; k > 0; k--) if (raw_bins[k] > 0) break;
      if (k == 0) begin
         r.status = STATUS_ALL_ZERO;
         return r;
      end
      nbin = k + 1;
      nbot = percentile_bin(cfg_base_pct, nbin);
      if (nbot == 0) nbot = 1;
      if (cfg_min_base > nbot) nbot = cfg_min_base;
      if (nbot >= nbin - 9) begin
         r.status = STATUS_BASE_HIGH;
         return r;
      end
      hmin = nbot;
      hmax = percentile_bin(cfg_top_pct, nbin);
      for (k = 0; k <= nbin && k < NUM_BINS; k++) smooth_bins[k] = raw_bins[k];
      for (k = nbot; k < nbin; k++)
         smooth_bins[k] = int'((longint'(raw_at(k - 1)) + 2 * longint'(raw_at(k))
                               + raw_at(k + 1)) >> 2);
      n_max = 0;
      for (k = nbot + 1; k < nbin; k++)
         if (smooth_at(k) > smooth_at(k - 1) && smooth_at(k) > smooth_at(k + 1)
             && n_max < MAX_PEAKS) begin
            peak_bins[n_max] = k;
            n_max++;
         end
      if (n_max == 0) begin
         r.status = STATUS_NO_MAXIMA;
         return r;
      end
      gpeak = 0;
      wpeak = 0;
      if (n_max == 1) begin
         npeak = peak_bins[0];
         one_peak = 1'b1;
      end else begin
         i1 = 0;
         i2 = 1;
         f1 = smooth_at(peak_bins[0]);
         f2 = smooth_at(peak_bins[1]);
         if (f1 < f2) begin
            i1 = 1;
            i2 = 0;
            fk = f1;
            f1 = f2;
            f2 = fk;
         end
         for (j = 2; j < n_max; j++) begin
            fk = smooth_at(peak_bins[j]);
            if (fk > f1) begin
               f2 = f1;
               i2 = i1;
               f1 = fk;
               i1 = j;
            end else if (fk > f2) begin
               f2 = fk;
               i2 = j;
            end
         end
         npeak = peak_bins[i1] < peak_bins[i2] ? peak_bins[i1] : peak_bins[i2];
         ntop = peak_bins[i1] < peak_bins[i2] ? peak_bins[i2] : peak_bins[i1];
         gpeak = npeak;
         wpeak = ntop;
         one_peak = 1'b0;
      end
      // valley below the lower peak
      for (k = npeak - 1; k > 0; k--)
         if (smooth_at(k) < smooth_at(k - 1) && smooth_at(k) < smooth_at(k + 1)) break;
      if (k > hmin) hmin = k;
      if (one_peak) begin
         gpeak = npeak;
         wpeak = npeak + (npeak - k);
      end
      numpts = 0;
      for (k = hmin; k < hmax; k++) numpts += raw_at(k);
      r.status = STATUS_OK;
      r.base_bin = hmin[14:0];
      r.top_bin = (hmax > 32767) ? 15'h7fff : hmax[14:0];
      r.gray_peak = gpeak[14:0];
      r.white_peak = wpeak[15:0];
      r.in_range_count = numpts[24:0];
      return r;
   endfunction

   // returns 1 when the item closes a data set; rsp then holds the prediction
   function automatic bit predict_voxel(hpvf_req_type item, output hpvf_rsp_type rsp);
      int v;
      rsp = '0;
      v = item.voxel_value;
      if (v >= 0 && voxel_count < MAX_VOXELS) begin
         raw_bins[v]++;
         voxel_count++;
         if (v > top_touched) top_touched = v;
      end
      if (!item.last_voxel) return 1'b0;
      rsp = histogram_limits();
      for (int k = 0; k <= top_touched + 1 && k < NUM_BINS; k++) begin
         raw_bins[k] = 0;
         smooth_bins[k] = 0;
      end
      top_touched = 0;
      voxel_count = 0;
      return 1'b1;
   endfunction

   task automatic send_voxel(hpvf_req_type item, bit typed, hpvf_rsp_type typed_rsp);
      hpvf_rsp_type rsp;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      if (predict_voxel(item, rsp)) expected_rsp_q.push_back(typed ? typed_rsp : rsp);
      // idle cycle by cycle with the phase's probability
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
   endtask

   task automatic write_csr(logic [1:0] idx, logic [14:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_BASE_PERCENT: cfg_base_pct = value[6:0];
         CSR_TOP_PERCENT:  cfg_top_pct = value[6:0];
         CSR_MIN_BASE_BIN: cfg_min_base = value;
         default: ;
      endcase
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      // let the clearing pass finish
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic voxel(int v, bit last);
      hpvf_req_type item;
      item.voxel_value = 16'(v);
      item.last_voxel = last;
      send_voxel(item, 1'b0, '0);
   endtask

   // one random data set; returns the number of counted voxels
   task automatic random_set(output int counted);
      int kind, len, c1, c2, w, v, teeth;
      counted = 0;
      kind = $urandom_range(99);
      if (kind < 4 && large_sets < 3) begin
         large_sets++;
         len = $urandom_range(40, 5);
         for (int i = 0; i < len; i++) begin
            v = $urandom_range(65535);
            if (v < 32768) counted++;
            voxel(v, i == len - 1);
         end
      end else if (kind < 8) begin
         // comb of 100 to 140 narrow teeth, on both sides of the maxima list limit
         teeth = $urandom_range(140, 100);
         for (int t = 1; t <= teeth; t++)
            for (int n = $urandom_range(5, 4); n > 0; n--) begin
               counted++;
               voxel(3 * t, t == teeth && n == 1);
            end
      end else if (kind < 20) begin
         len = $urandom_range(30, 1);
         for (int i = 0; i < len; i++) begin
            v = $urandom_range(3) == 0 ? -int'($urandom_range(32768, 1))
                                       : $urandom_range(60);
            if (v >= 0) counted++;
            voxel(v, i == len - 1);
         end
      end else begin
         // two blurred modes sharing one random width; the upper mode is drawn a third of the time
         len = $urandom_range(90, 20);
         c1 = $urandom_range(150, 10);
         c2 = c1 + $urandom_range(250, 15);
         w = $urandom_range(25, 2);
         for (int i = 0; i < len; i++) begin
            v = ($urandom_range(2) == 0 ? c2 : c1)
                + $urandom_range(w) - $urandom_range(w);
            if ($urandom_range(15) == 0) v = $urandom_range(20);
            if ($urandom_range(31) == 0) v = -1;
            if (v >= 0) counted++;
            voxel(v, i == len - 1);
         end
      end
   endtask

   typedef struct {
      int           value;
      bit           last;
      bit           typed;
      hpvf_rsp_type rsp;
   } stim_row_type;

   localparam hpvf_rsp_type ALL_ZERO_RSP  = '{status: STATUS_ALL_ZERO, default: '0};
   localparam hpvf_rsp_type BASE_HIGH_RSP = '{status: STATUS_BASE_HIGH, default: '0};
   localparam hpvf_rsp_type NO_MAX_RSP    = '{status: STATUS_NO_MAXIMA, default: '0};

   stim_row_type directed_rows[] = '{
      '{-32768, 1'b1, 1'b1, ALL_ZERO_RSP},
      '{0,      1'b0, 1'b0, '0},
      '{-1,     1'b1, 1'b1, ALL_ZERO_RSP},
      '{5,      1'b0, 1'b0, '0},
      '{5,      1'b1, 1'b1, BASE_HIGH_RSP},
      '{32767,  1'b1, 1'b1, NO_MAX_RSP},
      '{10,     1'b0, 1'b0, '0},
      '{10,     1'b0, 1'b0, '0},
      '{10,     1'b0, 1'b0, '0},
      '{11,     1'b0, 1'b0, '0},
      '{30,     1'b0, 1'b0, '0},
      '{30,     1'b0, 1'b0, '0},
      '{30,     1'b0, 1'b0, '0},
      '{30,     1'b0, 1'b0, '0},
      '{2,      1'b1, 1'b0, '0},
      '{20,     1'b0, 1'b0, '0},
      '{20,     1'b0, 1'b0, '0},
      '{20,     1'b0, 1'b0, '0},
      '{21,     1'b0, 1'b0, '0},
      '{19,     1'b0, 1'b0, '0},
      '{1,      1'b0, 1'b0, '0},
      '{16384,  1'b1, 1'b0, '0}
   };

   // receiver stalls
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result item: %p", rsp_data);
         end else begin
            hpvf_rsp_type want;
            want = expected_rsp_q.pop_front();
            if (want !== rsp_data) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result mismatch: expected %p, got %p", want, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("histogram_peak_valley_finder regression: fail");
         $finish;
      end
   end

   initial begin
      int counted, budget, done_items;
      int phase_base[6]  = '{50, 0, 100, 127, 0, 25};
      int phase_top[6]   = '{98, 127, 127, 0, 0, 100};
      int phase_min[6]   = '{1, 0, 32767, 1, 0, 3};
      int phase_idle[6]  = '{0, 81, 0, 28, 81, 0};
      int phase_stall[6] = '{0, 0, 81, 28, 81, 0};
      int phase_items[6] = '{300, 450, 80, 80, 400, 400};
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      large_sets = 0;
      top_touched = 0;
      voxel_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         hpvf_req_type item;
         item.voxel_value = 16'(directed_rows[i].value);
         item.last_voxel = directed_rows[i].last;
         send_voxel(item, directed_rows[i].typed, directed_rows[i].rsp);
      end

      for (int p = 0; p < 6; p++) begin
         settle();
         if (p == 4) begin
            phase_base[p] = $urandom_range(60, 10);
            phase_top[p] = $urandom_range(100, 70);
            phase_min[p] = $urandom_range(5);
         end
         if (p != 0) begin
            write_csr(CSR_BASE_PERCENT, 15'(phase_base[p]));
            write_csr(CSR_TOP_PERCENT, 15'(phase_top[p]));
            write_csr(CSR_MIN_BASE_BIN, 15'(phase_min[p]));
         end
         sender_idle_pct = phase_idle[p];
         receiver_stall_pct = phase_stall[p];
         done_items = 0;
         budget = phase_items[p];
         while (done_items < budget) begin
            random_set(counted);
            done_items += counted;
         end
      end

      settle();
      if (mismatch_count == 0 && expected_rsp_q.size() == 0)
         $display("histogram_peak_valley_finder regression: pass");
      else
         $display("histogram_peak_valley_finder regression: fail");
      $finish;
   end

endmodule

// ===== histogram_peak_valley_finder.f =====
rtl/hpvf_pkg.sv
rtl/hpvf_ram.sv
rtl/hpvf_scan.sv
rtl/hpvf_window.sv
rtl/histogram_peak_valley_finder.sv
bench/tb.sv
